### design/fbd_pkg.sv
package fbd_pkg;

	localparam int SAMPLE_BITS_DEF = 16;
	localparam int CNT_BITS = 6;
	localparam int PHASE_BITS = 16;
	localparam int QUEUE_DEPTH = 2;
	localparam int ADDR_BITS = 3;
	localparam int DATA_BITS = 32;

	localparam logic [CNT_BITS-1:0] BASE_COUNT_RESET = 6'd40;
	localparam logic [PHASE_BITS-1:0] PHASE_STEP_RESET = 16'd33927;
	localparam logic [CNT_BITS-1:0] CNT_MAX = '1;

	typedef enum logic {
		REG_BASE_COUNT = 1'b0,
		REG_PHASE_STEP = 1'b1
	} fbd_reg_t;

	typedef struct packed {
		logic [CNT_BITS-1:0]   base_count;
		logic [PHASE_BITS-1:0] phase_step;
	} fbd_cfg_t;

	typedef struct packed {
		logic full;
		logic valid;
	} fbd_q_status_t;

endpackage

### design/fbd_stream_if.sv
interface fbd_sample_if #(
	parameter int SAMPLE_BITS = 16
) ();
	logic                   valid;
	logic                   ready;
	logic [SAMPLE_BITS-1:0] sample_in;

	modport source (output valid, output sample_in, input ready);
	modport sink (input valid, input sample_in, output ready);
endinterface

interface fbd_avg_if #(
	parameter int SAMPLE_BITS = 16
) ();
	logic                   valid;
	logic                   ready;
	logic [SAMPLE_BITS-1:0] avg_sample;

	modport source (output valid, output avg_sample, input ready);
	modport sink (input valid, input avg_sample, output ready);
endinterface

### design/fbd_queue.sv
module fbd_queue #(
	parameter int W = 28
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  logic [W-1:0]          push_data,
	input  logic                  pop,
	output logic [W-1:0]          pop_data,
	output fbd_pkg::fbd_q_status_t status
);
	import fbd_pkg::*;

	localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int FILL_BITS = $clog2(QUEUE_DEPTH + 1);

	logic [W-1:0]         mem_q [QUEUE_DEPTH];
	logic [PTR_BITS-1:0]  wr_ptr_q;
	logic [PTR_BITS-1:0]  rd_ptr_q;
	logic [FILL_BITS-1:0] fill_q;

	function automatic logic [PTR_BITS-1:0] next_ptr(input logic [PTR_BITS-1:0] p);
		return (p == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_BITS'(1);
	endfunction

	assign status.full  = (fill_q == FILL_BITS'(QUEUE_DEPTH));
	assign status.valid = (fill_q != '0);
	assign pop_data     = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			case ({push, pop})
				2'b10:   fill_q <= fill_q + FILL_BITS'(1);
				2'b01:   fill_q <= fill_q - FILL_BITS'(1);
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

### design/fbd_front.sv
module fbd_front #(
	parameter int SAMPLE_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	fbd_sample_if.sink                     in_ch,
	input  fbd_pkg::fbd_cfg_t              cfg,
	input  fbd_pkg::fbd_q_status_t         q_stat,
	output logic                           push,
	output logic [SAMPLE_BITS+5:0]         push_sum,
	output logic [fbd_pkg::CNT_BITS-1:0]   push_cnt
);
	import fbd_pkg::*;

	localparam int SUM_BITS = SAMPLE_BITS + CNT_BITS;

	logic [SUM_BITS-1:0]   sum_q, sum_n;
	logic [CNT_BITS-1:0]   count_q, cnt_n;
	logic [CNT_BITS-1:0]   target_q, long_win;
	logic [PHASE_BITS-1:0] phase_q, phase_n;
	logic                  accept, emit;

	assign in_ch.ready = !q_stat.full;
	assign accept      = in_ch.valid && in_ch.ready;

	assign sum_n    = sum_q + {{CNT_BITS{1'b0}}, in_ch.sample_in};
	assign cnt_n    = count_q + CNT_BITS'(1);
	assign emit     = (cnt_n >= target_q);
	assign phase_n  = phase_q + cfg.phase_step;
	assign long_win = (cfg.base_count == CNT_MAX) ? CNT_MAX : cfg.base_count + CNT_BITS'(1);

	assign push     = accept && emit;
	assign push_sum = sum_n;
	assign push_cnt = (cnt_n == '0) ? CNT_BITS'(1) : cnt_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q    <= '0;
			count_q  <= '0;
			target_q <= BASE_COUNT_RESET;
			phase_q  <= '0;
		end else if (accept) begin
			if (emit) begin
				sum_q    <= '0;
				count_q  <= '0;
				phase_q  <= phase_n;
				target_q <= (phase_n >= cfg.phase_step) ? cfg.base_count : long_win;
			end else begin
				sum_q   <= sum_n;
				count_q <= cnt_n;
			end
		end
	end

endmodule

### design/fbd_divider.sv
module fbd_divider #(
	parameter int SAMPLE_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         q_valid,
	input  logic [SAMPLE_BITS+5:0]       q_sum,
	input  logic [fbd_pkg::CNT_BITS-1:0] q_cnt,
	output logic                         pop,
	fbd_avg_if.source                    out_ch
);
	import fbd_pkg::*;

	localparam int SUM_BITS = SAMPLE_BITS + CNT_BITS;
	localparam int STEP_BITS = $clog2(SUM_BITS);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_HOLD
	} state_t;

	state_t                 state_q;
	logic [SUM_BITS-1:0]    acc_q, acc_n;
	logic [CNT_BITS-1:0]    rem_q, rem_n;
	logic [CNT_BITS-1:0]    div_q;
	logic [STEP_BITS-1:0]   step_q;
	logic [CNT_BITS:0]      trial;
	logic                   ge;
	logic                   out_valid_q;
	logic [SAMPLE_BITS-1:0] out_data_q;
	logic                   slot_free;
	logic                   out_load;

	// restoring division, one quotient bit per cycle
	assign trial = {rem_q, acc_q[SUM_BITS-1]};
	assign ge    = (trial >= {1'b0, div_q});
	assign rem_n = ge ? CNT_BITS'(trial - {1'b0, div_q}) : trial[CNT_BITS-1:0];
	assign acc_n = {acc_q[SUM_BITS-2:0], ge};

	assign slot_free = !out_valid_q || out_ch.ready;
	assign pop       = (state_q == ST_IDLE) && q_valid;
	assign out_load  = slot_free && ((state_q == ST_HOLD) ||
		((state_q == ST_RUN) && (step_q == STEP_BITS'(SUM_BITS - 1))));

	assign out_ch.valid      = out_valid_q;
	assign out_ch.avg_sample = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
			acc_q       <= '0;
			rem_q       <= '0;
			div_q       <= '0;
			step_q      <= '0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						acc_q   <= q_sum;
						rem_q   <= '0;
						div_q   <= q_cnt;
						step_q  <= '0;
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					rem_q  <= rem_n;
					step_q <= step_q + STEP_BITS'(1);
					if (step_q == STEP_BITS'(SUM_BITS - 1)) begin
						if (slot_free) begin
							out_data_q <= acc_n[SAMPLE_BITS-1:0];
							state_q    <= ST_IDLE;
						end else begin
							acc_q   <= acc_n;
							state_q <= ST_HOLD;
						end
					end else begin
						acc_q <= acc_n;
					end
				end
				ST_HOLD: begin
					if (slot_free) begin
						out_data_q <= acc_q[SAMPLE_BITS-1:0];
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

### design/fractional_boxcar_decimator_top.sv
// Boxcar averaging decimator with a fractional ratio. Samples are taken one per cycle
// while the two-entry window queue has room; each finished window (sum and length) is
// queued and averaged by a bit-serial restoring divider (a load state, then one quotient
// bit per sum bit), which takes the next window only once its result has left the run
// and hold states, so with short windows the divider sets the sustained rate and
// back-pressures the input. A result waits in an output register until it is taken.
// Registers: base_count at 0x0, phase_step at 0x4; new values take effect when the next
// window length is chosen.
module fractional_boxcar_decimator_top #(
	parameter int SAMPLE_BITS = fbd_pkg::SAMPLE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	fbd_sample_if.sink                    in_ch,
	fbd_avg_if.source                     out_ch,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [fbd_pkg::ADDR_BITS-1:0] paddr,
	input  logic [fbd_pkg::DATA_BITS-1:0] pwdata,
	output logic [fbd_pkg::DATA_BITS-1:0] prdata,
	output logic                          pready
);
	import fbd_pkg::*;

	localparam int SUM_BITS = SAMPLE_BITS + CNT_BITS;
	localparam int ENTRY_BITS = SUM_BITS + CNT_BITS;

	fbd_cfg_t            cfg_q;
	fbd_q_status_t       q_stat;
	fbd_reg_t            reg_sel;
	logic                cfg_wr;
	logic                q_push, q_pop;
	logic [SUM_BITS-1:0] push_sum;
	logic [CNT_BITS-1:0] push_cnt;
	logic [ENTRY_BITS-1:0] pop_data;

	assign pready  = 1'b1;
	assign reg_sel = fbd_reg_t'(paddr[2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_comb begin
		case (reg_sel)
			REG_BASE_COUNT: prdata = {{(DATA_BITS-CNT_BITS){1'b0}}, cfg_q.base_count};
			REG_PHASE_STEP: prdata = {{(DATA_BITS-PHASE_BITS){1'b0}}, cfg_q.phase_step};
			default:        prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.base_count <= BASE_COUNT_RESET;
			cfg_q.phase_step <= PHASE_STEP_RESET;
		end else if (cfg_wr) begin
			case (reg_sel)
				REG_BASE_COUNT: cfg_q.base_count <= pwdata[CNT_BITS-1:0];
				REG_PHASE_STEP: cfg_q.phase_step <= pwdata[PHASE_BITS-1:0];
				default:        cfg_q <= cfg_q;
			endcase
		end
	end

	fbd_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (in_ch),
		.cfg      (cfg_q),
		.q_stat   (q_stat),
		.push     (q_push),
		.push_sum (push_sum),
		.push_cnt (push_cnt)
	);

	fbd_queue #(.W(ENTRY_BITS)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data ({push_sum, push_cnt}),
		.pop       (q_pop),
		.pop_data  (pop_data),
		.status    (q_stat)
	);

	fbd_divider #(.SAMPLE_BITS(SAMPLE_BITS)) u_divider (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_stat.valid),
		.q_sum   (pop_data[ENTRY_BITS-1:CNT_BITS]),
		.q_cnt   (pop_data[CNT_BITS-1:0]),
		.pop     (q_pop),
		.out_ch  (out_ch)
	);

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_stat.full)
		else $error("window pushed into a full queue");

	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_stat.valid)
		else $error("divider took a window from an empty queue");

	a_pop_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> (pop_data[CNT_BITS-1:0] != '0))
		else $error("zero window length reached the divider");

endmodule

### tb/sv/fractional_boxcar_decimator_top_tb.sv
module fractional_boxcar_decimator_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import fbd_pkg::*;

	localparam int SB = SAMPLE_BITS_DEF;
	localparam int SUM_BITS = SB + CNT_BITS;
	localparam int STALL_LIMIT = 5000;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_CYCLES = SB + 16;

	typedef enum int {
		IDLE_NONE,
		IDLE_SEND,
		IDLE_RECV,
		IDLE_BOTH
	} idle_mode_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 psel;
	logic                 penable;
	logic                 pwrite;
	logic [ADDR_BITS-1:0] paddr;
	logic [DATA_BITS-1:0] pwdata;
	logic [DATA_BITS-1:0] prdata;
	logic                 pready;

	fbd_sample_if #(.SAMPLE_BITS(SB)) in_ch ();
	fbd_avg_if #(.SAMPLE_BITS(SB)) out_ch ();

	fractional_boxcar_decimator_top #(
		.SAMPLE_BITS(SB)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// shadow of the averaging state and registers
	fbd_cfg_t              cfg_shadow;
	logic [SUM_BITS-1:0]   win_sum;
	logic [CNT_BITS-1:0]   win_len;
	logic [CNT_BITS-1:0]   win_target;
	logic [PHASE_BITS-1:0] ratio_phase;

	logic [SB-1:0] sample_q[$];
	logic [SB-1:0] avg_due_q[$];

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_reqs = 0;
	int hold_done = 0;
	int hold_left = 0;
	int err_cnt = 0;
	int samples_taken = 0;
	int avgs_checked = 0;
	int settings_cnt = 0;
	int idle_cyc = 0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic void flag_error(input string msg);
		if (err_cnt < 10)
			$display("ERROR at %0t: %s", $time, msg);
		err_cnt++;
	endfunction

	// adds one sample to the window; returns 1 with the average when the window closes
	function automatic logic fold_sample(input logic [SB-1:0] s, output logic [SB-1:0] avg);
		logic [SUM_BITS-1:0] n;
		win_sum = win_sum + SUM_BITS'(s);
		win_len = win_len + 1'b1;
		avg = '0;
		fold_sample = 1'b0;
		if (win_len >= win_target) begin
			n = (win_len == '0) ? SUM_BITS'(1) : SUM_BITS'(win_len);
			avg = SB'(win_sum / n);
			ratio_phase = ratio_phase + cfg_shadow.phase_step;
			if (ratio_phase >= cfg_shadow.phase_step)
				win_target = cfg_shadow.base_count;
			else if (cfg_shadow.base_count == CNT_MAX)
				win_target = CNT_MAX;
			else
				win_target = cfg_shadow.base_count + 1'b1;
			win_len = '0;
			win_sum = '0;
			fold_sample = 1'b1;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
		end else if (!in_ch.valid || in_ch.ready) begin
			if (sample_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				in_ch.valid <= 1'b1;
				in_ch.sample_in <= sample_q.pop_front();
			end else begin
				in_ch.valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_ch.ready <= 1'b0;
		end else if (hold_done != hold_reqs) begin
			hold_done <= hold_done + 1;
			hold_left <= HOLD_CYCLES;
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// output checked before the input is folded in, so ordering within an edge is fixed
	always @(posedge clk) begin
		logic [SB-1:0] avg;
		logic [SB-1:0] want;
		if (arst_n) begin
			if (out_ch.valid && out_ch.ready) begin
				if (avg_due_q.size() == 0) begin
					flag_error($sformatf("unexpected avg_sample %0h", out_ch.avg_sample));
				end else begin
					want = avg_due_q.pop_front();
					avgs_checked++;
					if (out_ch.avg_sample !== want)
						flag_error($sformatf("avg_sample expected %0h got %0h",
							want, out_ch.avg_sample));
				end
			end
			if (in_ch.valid && in_ch.ready) begin
				samples_taken++;
				if (fold_sample(in_ch.sample_in, avg))
					avg_due_q.push_back(avg);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel) begin
				idle_cyc <= 0;
			end else if (idle_cyc >= STALL_LIMIT) begin
				$display("Timeout: no request moved for %0d cycles, %0d averages outstanding",
					idle_cyc, avg_due_q.size());
				$display("Testbench completed WITH ERRORS");
				$finish;
			end else begin
				idle_cyc <= idle_cyc + 1;
			end
		end
	end

	task automatic apb_write(input fbd_reg_t r, input logic [DATA_BITS-1:0] v);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {r, 2'b00};
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		if (r == REG_BASE_COUNT)
			cfg_shadow.base_count = v[CNT_BITS-1:0];
		else
			cfg_shadow.phase_step = v[PHASE_BITS-1:0];
	endtask

	task automatic apb_check(input fbd_reg_t r, input logic [DATA_BITS-1:0] want);
		logic [DATA_BITS-1:0] got;
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= {r, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		@(negedge clk);
		got = prdata;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		if (got !== want)
			flag_error($sformatf("register %s read %0h, expected %0h", r.name(), got, want));
	endtask

	// wait for all requests and averages, then let a partial window settle
	task automatic drain();
		while (sample_q.size() != 0 || in_ch.valid || avg_due_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic run_phase(input logic [CNT_BITS-1:0] base, input logic [PHASE_BITS-1:0] step,
		input int n, input idle_mode_t mode, input bit hold);
		logic [SB-1:0] s;
		apb_write(REG_BASE_COUNT, DATA_BITS'(base));
		apb_write(REG_PHASE_STEP, DATA_BITS'(step));
		apb_check(REG_BASE_COUNT, DATA_BITS'(base));
		apb_check(REG_PHASE_STEP, DATA_BITS'(step));
		settings_cnt++;
		send_idle_pct = (mode == IDLE_SEND) ? 71 : (mode == IDLE_BOTH) ? 24 : 0;
		recv_stall_pct = (mode == IDLE_RECV) ? 71 : (mode == IDLE_BOTH) ? 24 : 0;
		if (hold)
			hold_reqs++;
		repeat (n) begin
			case ($urandom_range(9))
				0: s = '0;
				1: s = '1;
				default: s = SB'($urandom);
			endcase
			sample_q.push_back(s);
		end
		drain();
	endtask

	initial begin
		logic [SB-1:0] corner_vals[8];
		corner_vals = '{16'h0000, 16'hFFFF, 16'h5555, 16'hAAAA,
			16'h0001, 16'hFFFE, 16'h8000, 16'h7FFF};
		in_ch.valid = 1'b0;
		in_ch.sample_in = '0;
		out_ch.ready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		cfg_shadow.base_count = BASE_COUNT_RESET;
		cfg_shadow.phase_step = PHASE_STEP_RESET;
		win_sum = '0;
		win_len = '0;
		win_target = BASE_COUNT_RESET;
		ratio_phase = '0;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// first window keeps its reset length although the registers change under it
		apb_write(REG_BASE_COUNT, DATA_BITS'(1));
		apb_write(REG_PHASE_STEP, DATA_BITS'(0));
		settings_cnt++;
		repeat (39) sample_q.push_back('1);
		sample_q.push_back(16'hFFFE);
		foreach (corner_vals[i])
			sample_q.push_back(corner_vals[i]);
		drain();

		run_phase(6'd0, 16'd0, 150, IDLE_RECV, 1'b0);
		run_phase(6'd63, 16'hFFFF, 200, IDLE_NONE, 1'b0);
		run_phase(6'd62, 16'd1, 130, IDLE_SEND, 1'b0);
		run_phase(BASE_COUNT_RESET, PHASE_STEP_RESET, 250, IDLE_BOTH, 1'b0);
		run_phase(CNT_BITS'($urandom_range(8, 1)), PHASE_BITS'($urandom), 200, IDLE_NONE, 1'b1);
		run_phase(6'd1, 16'hFFFF, 150, IDLE_BOTH, 1'b0);
		run_phase(CNT_BITS'($urandom_range(63)), PHASE_BITS'($urandom), 120, IDLE_SEND, 1'b0);
		run_phase(CNT_BITS'($urandom_range(12, 2)), PHASE_BITS'($urandom), 150, IDLE_RECV,
			1'b0);

		if (avg_due_q.size() != 0)
			flag_error($sformatf("%0d averages never arrived", avg_due_q.size()));
		$display("Covered %0d samples over %0d register settings (windows of 1 to 63 samples)",
			samples_taken, settings_cnt);
		$display("Checked %0d averages, %0d failures", avgs_checked, err_cnt);
		if (err_cnt == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
